@@ hw/rtl/tba_pkg.sv @@
// Package for the three-body acceleration unit: payload structs and shared constants.
// Used by every module under hw/rtl; depends on nothing.
package tba_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FAR_BITS      = 25;
    localparam int FRAC_BITS     = 16;

    typedef struct packed {
        logic signed [31:0] body1_x;
        logic signed [31:0] body1_y;
        logic signed [31:0] body2_x;
        logic signed [31:0] body2_y;
        logic signed [31:0] body3_x;
        logic signed [31:0] body3_y;
        logic signed [31:0] body1_vx;
        logic signed [31:0] body1_vy;
        logic signed [31:0] body2_vx;
        logic signed [31:0] body2_vy;
        logic signed [31:0] body3_vx;
        logic signed [31:0] body3_vy;
    } tba_in_t;

    typedef struct packed {
        logic signed [31:0] rate1_x;
        logic signed [31:0] rate1_y;
        logic signed [31:0] rate2_x;
        logic signed [31:0] rate2_y;
        logic signed [31:0] rate3_x;
        logic signed [31:0] rate3_y;
        logic signed [31:0] accel1_x;
        logic signed [31:0] accel1_y;
        logic signed [31:0] accel2_x;
        logic signed [31:0] accel2_y;
        logic signed [31:0] accel3_x;
        logic signed [31:0] accel3_y;
    } tba_out_t;

    // Signed contribution of one pair, wide enough for any saturating value.
    typedef logic signed [63:0] tba_contrib_t;

    typedef struct packed {
        tba_contrib_t cx;
        tba_contrib_t cy;
    } tba_pair_t;

endpackage

@@ hw/rtl/tba_pair.sv @@
// Pipelined pair force: difference, distance, inverse cube and scaling for one body pair.
// Depends on tba_pkg. Advances when en is high.
module tba_pair
    import tba_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic signed [31:0] xi,
    input  logic signed [31:0] yi,
    input  logic signed [31:0] xj,
    input  logic signed [31:0] yj,
    output tba_pair_t          res
);

    localparam int SQ_STEPS = 26;
    localparam int DV_STEPS = 32;

    // Stage 1: differences.
    logic [32:0] mx_reg, my_reg;
    logic        nx_reg, ny_reg, zero_reg;
    logic signed [32:0] dx, dy;
    always_comb begin
        dx = 33'(signed'(xj)) - 33'(signed'(xi));
        dy = 33'(signed'(yj)) - 33'(signed'(yi));
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            nx_reg <= dx[32];
            ny_reg <= dy[32];
            mx_reg <= dx[32] ? 33'(-dx) : 33'(dx);
            my_reg <= dy[32] ? 33'(-dy) : 33'(dy);
        end
    end
    logic far1;
    assign far1 = (|mx_reg[32:FAR_BITS]) | (|my_reg[32:FAR_BITS]);

    // Stage 2: squares (25 x 25).
    logic [24:0] ax_reg, ay_reg;
    logic [49:0] sx_reg, sy_reg;
    logic        n2x_reg, n2y_reg, z2_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg  <= mx_reg[24:0];
            ay_reg  <= my_reg[24:0];
            sx_reg  <= 50'(mx_reg[24:0]) * 50'(mx_reg[24:0]);
            sy_reg  <= 50'(my_reg[24:0]) * 50'(my_reg[24:0]);
            n2x_reg <= nx_reg;
            n2y_reg <= ny_reg;
            z2_reg  <= far1 | ((mx_reg == 33'd0) & (my_reg == 33'd0));
        end
    end
    logic [50:0] s_sum;
    assign s_sum = 51'(sx_reg) + 51'(sy_reg);

    // Square root: one result bit per stage, 26 stages.
    logic [50:0] sq_s   [SQ_STEPS+1];
    logic [25:0] sq_r   [SQ_STEPS+1];
    logic [24:0] sq_ax  [SQ_STEPS+1];
    logic [24:0] sq_ay  [SQ_STEPS+1];
    logic        sq_nx  [SQ_STEPS+1];
    logic        sq_ny  [SQ_STEPS+1];
    logic        sq_z   [SQ_STEPS+1];
    assign sq_s[0]  = s_sum;
    assign sq_r[0]  = '0;
    assign sq_ax[0] = ax_reg;
    assign sq_ay[0] = ay_reg;
    assign sq_nx[0] = n2x_reg;
    assign sq_ny[0] = n2y_reg;
    assign sq_z[0]  = z2_reg;
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam int SH = 2 * (SQ_STEPS - 1 - k);
        logic [50:0] trial;
        logic [50:0] rem_next;
        logic [25:0] r_next;
        logic [25:0] s_reg_r;
        always_comb begin
            trial = 51'({sq_r[k], 2'b01}) << SH;
            if (sq_s[k] >= trial) begin
                rem_next = sq_s[k] - trial;
                r_next   = {sq_r[k][24:0], 1'b1};
            end else begin
                rem_next = sq_s[k];
                r_next   = {sq_r[k][24:0], 1'b0};
            end
        end
        logic [50:0] s_q;
        logic [25:0] r_q;
        logic [24:0] ax_q, ay_q;
        logic        nx_q, ny_q, z_q;
        always_ff @(posedge aclk) begin
            if (en) begin
                s_q  <= rem_next;
                r_q  <= r_next;
                ax_q <= sq_ax[k];
                ay_q <= sq_ay[k];
                nx_q <= sq_nx[k];
                ny_q <= sq_ny[k];
                z_q  <= sq_z[k];
            end
        end
        assign s_reg_r     = r_q;
        assign sq_s[k+1]  = s_q;
        assign sq_r[k+1]  = s_reg_r;
        assign sq_ax[k+1] = ax_q;
        assign sq_ay[k+1] = ay_q;
        assign sq_nx[k+1] = nx_q;
        assign sq_ny[k+1] = ny_q;
        assign sq_z[k+1]  = z_q;
    end

    // Normalize: b = bit length of R, n = R << (32 - b).
    logic [25:0] rr;
    logic [5:0]  blen;
    always_comb begin
        rr   = sq_r[SQ_STEPS];
        blen = '0;
        for (int i = 0; i < 26; i++) begin
            if (rr[i]) blen = 6'(i + 1);
        end
    end
    logic [31:0] n_reg;
    logic [5:0]  b_reg;
    logic [24:0] nax_reg, nay_reg;
    logic        nnx_reg, nny_reg, nz_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg   <= 32'(rr) << (6'd32 - blen);
            b_reg   <= blen;
            nax_reg <= sq_ax[SQ_STEPS];
            nay_reg <= sq_ay[SQ_STEPS];
            nnx_reg <= sq_nx[SQ_STEPS];
            nny_reg <= sq_ny[SQ_STEPS];
            nz_reg  <= sq_z[SQ_STEPS] | (blen == 6'd0);
        end
    end

    // Divider 2^62 / n: n in [2^31, 2^32), quotient below 2^32. One bit per stage.
    logic [32:0] dv_rem [DV_STEPS+1];
    logic [31:0] dv_q   [DV_STEPS+1];
    logic [31:0] dv_n   [DV_STEPS+1];
    logic [5:0]  dv_b   [DV_STEPS+1];
    logic [24:0] dv_ax  [DV_STEPS+1];
    logic [24:0] dv_ay  [DV_STEPS+1];
    logic        dv_nx  [DV_STEPS+1];
    logic        dv_ny  [DV_STEPS+1];
    logic        dv_z   [DV_STEPS+1];
    // Dividend 2^62: the top 31 bits are 2^30, below n, so start with rem = 2^30.
    assign dv_rem[0] = 33'h0_4000_0000;
    assign dv_q[0]   = '0;
    assign dv_n[0]   = n_reg;
    assign dv_b[0]   = b_reg;
    assign dv_ax[0]  = nax_reg;
    assign dv_ay[0]  = nay_reg;
    assign dv_nx[0]  = nnx_reg;
    assign dv_ny[0]  = nny_reg;
    assign dv_z[0]   = nz_reg | (n_reg == 32'd0);
    for (genvar k = 0; k < DV_STEPS; k++) begin : g_div
        logic [33:0] sh;
        logic [32:0] rem_next;
        logic        qb;
        always_comb begin
            sh = {dv_rem[k], 1'b0};
            if (sh >= 34'(dv_n[k])) begin
                rem_next = 33'(sh - 34'(dv_n[k]));
                qb       = 1'b1;
            end else begin
                rem_next = sh[32:0];
                qb       = 1'b0;
            end
        end
        logic [32:0] rem_q;
        logic [31:0] q_q, n_q;
        logic [5:0]  b_q;
        logic [24:0] ax_q, ay_q;
        logic        nx_q, ny_q, z_q;
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_q <= rem_next;
                q_q   <= {dv_q[k][30:0], qb};
                n_q   <= dv_n[k];
                b_q   <= dv_b[k];
                ax_q  <= dv_ax[k];
                ay_q  <= dv_ay[k];
                nx_q  <= dv_nx[k];
                ny_q  <= dv_ny[k];
                z_q   <= dv_z[k];
            end
        end
        assign dv_rem[k+1] = rem_q;
        assign dv_q[k+1]   = q_q;
        assign dv_n[k+1]   = n_q;
        assign dv_b[k+1]   = b_q;
        assign dv_ax[k+1]  = ax_q;
        assign dv_ay[k+1]  = ay_q;
        assign dv_nx[k+1]  = nx_q;
        assign dv_ny[k+1]  = ny_q;
        assign dv_z[k+1]   = z_q;
    end

    // Cube: u2 = (u*u) >> 31, M = (u2*u) >> 31.
    logic [31:0] u;
    assign u = dv_q[DV_STEPS];
    logic [32:0] u2_reg;
    logic [31:0] u_reg;
    logic [5:0]  cb_reg;
    logic [24:0] cax_reg, cay_reg;
    logic        cnx_reg, cny_reg, cz_reg;
    logic [63:0] uu;
    assign uu = 64'(u) * 64'(u);
    always_ff @(posedge aclk) begin
        if (en) begin
            u2_reg  <= uu[63:31];
            u_reg   <= u;
            cb_reg  <= dv_b[DV_STEPS];
            cax_reg <= dv_ax[DV_STEPS];
            cay_reg <= dv_ay[DV_STEPS];
            cnx_reg <= dv_nx[DV_STEPS];
            cny_reg <= dv_ny[DV_STEPS];
            cz_reg  <= dv_z[DV_STEPS];
        end
    end
    logic [64:0] uuu;
    assign uuu = 65'(u2_reg) * 65'(u_reg);
    logic [33:0] m_reg;
    logic [5:0]  mb_reg;
    logic [24:0] max_reg, may_reg;
    logic        mnx_reg, mny_reg, mz_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg   <= uuu[64:31];
            mb_reg  <= cb_reg;
            max_reg <= cax_reg;
            may_reg <= cay_reg;
            mnx_reg <= cnx_reg;
            mny_reg <= cny_reg;
            mz_reg  <= cz_reg;
        end
    end

    // Scale: |D| * M, 25 x 34 bits.
    logic [58:0] px_reg, py_reg;
    logic [5:0]  pb_reg;
    logic        pnx_reg, pny_reg, pz_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg  <= 59'(max_reg) * 59'(m_reg);
            py_reg  <= 59'(may_reg) * 59'(m_reg);
            pb_reg  <= mb_reg;
            pnx_reg <= mnx_reg;
            pny_reg <= mny_reg;
            pz_reg  <= mz_reg;
        end
    end

    // Shift by e = 3b - 20, in 64-bit unsigned arithmetic as the product wraps there.
    logic [7:0]  e3;
    logic [63:0] qx, qy;
    always_comb begin
        e3 = 8'(pb_reg) * 8'd3;
        if (e3 >= 8'd20) begin
            qx = 64'(px_reg) >> (e3 - 8'd20);
            qy = 64'(py_reg) >> (e3 - 8'd20);
        end else begin
            qx = 64'(px_reg) << (8'd20 - e3);
            qy = 64'(py_reg) << (8'd20 - e3);
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            res.cx <= pz_reg ? '0 : (pnx_reg ? -signed'(qx) : signed'(qx));
            res.cy <= pz_reg ? '0 : (pny_reg ? -signed'(qy) : signed'(qy));
        end
    end

endmodule

@@ hw/rtl/tba_sum.sv @@
// Combines the three pair contributions into saturated accelerations, one register stage.
// Depends on tba_pkg.
module tba_sum
    import tba_pkg::*;
(
    input  logic                            aclk,
    input  logic                            en,
    input  tba_pair_t                       c12,
    input  tba_pair_t                       c23,
    input  tba_pair_t                       c13,
    output logic signed [WORD_BITS_DEF-1:0] acc_reg [6]
);

    function automatic logic signed [WORD_BITS_DEF-1:0] sat(input logic signed [64:0] v);
        logic signed [64:0] hi;
        logic signed [64:0] lo;
        hi = 65'((65'sd1 <<< (WORD_BITS_DEF - 1)) - 65'sd1);
        lo = -hi - 65'sd1;
        if (v > hi) return hi[WORD_BITS_DEF-1:0];
        if (v < lo) return lo[WORD_BITS_DEF-1:0];
        return v[WORD_BITS_DEF-1:0];
    endfunction

    logic signed [64:0] s [6];
    always_comb begin
        s[0] = 65'(c12.cx) + 65'(c13.cx);
        s[1] = 65'(c12.cy) + 65'(c13.cy);
        s[2] = 65'(c23.cx) - 65'(c12.cx);
        s[3] = 65'(c23.cy) - 65'(c12.cy);
        s[4] = -65'(c23.cx) - 65'(c13.cx);
        s[5] = -65'(c23.cy) - 65'(c13.cy);
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 6; i++) acc_reg[i] <= sat(s[i]);
        end
    end

endmodule

@@ hw/rtl/three_body_acceleration_unit.sv @@
// Throughput: one request per cycle, unless the output is stalled.
// Each pair runs through a 26-stage square root and a 32-stage divider, one bit a stage.
// The whole pipeline advances when the result register is free or being taken.
// Reset (aresetn, synchronous, active low) clears the valid bits only.
// Depends on tba_pkg, tba_pair and tba_sum.
module three_body_acceleration_unit
    import tba_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tba_in_t  s_data,
    input  logic     m_ready,
    output logic     m_valid,
    output tba_out_t m_data
);

    localparam int LAT = 66;

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    logic [LAT-1:0] vld_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end
    assign m_valid = vld_reg[LAT-1];

    logic [191:0] vel_reg [LAT];
    always_ff @(posedge aclk) begin
        if (en) begin
            vel_reg[0] <= {s_data.body1_vx, s_data.body1_vy, s_data.body2_vx,
                           s_data.body2_vy, s_data.body3_vx, s_data.body3_vy};
            for (int i = 1; i < LAT; i++) vel_reg[i] <= vel_reg[i-1];
        end
    end

    tba_pair_t c12, c23, c13;
    tba_pair u_p12 (.aclk, .en, .xi(s_data.body1_x), .yi(s_data.body1_y),
                    .xj(s_data.body2_x), .yj(s_data.body2_y), .res(c12));
    tba_pair u_p23 (.aclk, .en, .xi(s_data.body2_x), .yi(s_data.body2_y),
                    .xj(s_data.body3_x), .yj(s_data.body3_y), .res(c23));
    tba_pair u_p13 (.aclk, .en, .xi(s_data.body1_x), .yi(s_data.body1_y),
                    .xj(s_data.body3_x), .yj(s_data.body3_y), .res(c13));

    logic signed [WORD_BITS_DEF-1:0] acc [6];
    tba_sum u_sum (
        .aclk, .en, .c12, .c23, .c13, .acc_reg(acc)
    );

    always_comb begin
        {m_data.rate1_x, m_data.rate1_y, m_data.rate2_x,
         m_data.rate2_y, m_data.rate3_x, m_data.rate3_y} = vel_reg[LAT-1];
        m_data.accel1_x = 32'(acc[0]);
        m_data.accel1_y = 32'(acc[1]);
        m_data.accel2_x = 32'(acc[2]);
        m_data.accel2_y = 32'(acc[3]);
        m_data.accel3_x = 32'(acc[4]);
        m_data.accel3_y = 32'(acc[5]);
    end

endmodule

@@ hw/rtl/tba_checker.sv @@
// Port-level checker for three_body_acceleration_unit, bound to the top level.
// Depends on tba_pkg.
module tba_checker
    import tba_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input tba_out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result changed while stalled.");

    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("Request taken while output stalled.");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("Input blocked with empty output.");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid after reset.");

endmodule

bind three_body_acceleration_unit tba_checker u_tba_checker (
    .aclk, .aresetn, .s_ready, .m_valid, .m_ready, .m_data
);
